### rtl/core/csq_pkg.sv
// ----------------------------------------------------------------------------
// CSV quote tokenizer package
// Shared types and constants for the strict-quote CSV tokenizer.
// ----------------------------------------------------------------------------
package csq_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned QUEUE_DEPTH = 4;

    // Token kinds on the result channel.
    localparam logic [KIND_W-1:0] KIND_DATA       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIELD_END  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RECORD_END = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR      = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUOTE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_END1 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_END2 = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [BYTE_W-1:0] RST_DELIMITER = 8'd44;
    localparam logic [BYTE_W-1:0] RST_QUOTE     = 8'd34;
    localparam logic [BYTE_W-1:0] RST_LINE_END1 = 8'd10;
    localparam logic [BYTE_W-1:0] RST_LINE_END2 = 8'd13;

    // One classified byte as it travels from the front end to the back end.
    typedef struct packed {
        logic              is_nl;
        logic              delim_hit;
        logic              quote_hit;
        logic [BYTE_W-1:0] data;
    } csq_class_t;

    typedef struct packed {
        logic [BYTE_W-1:0] delimiter;
        logic [BYTE_W-1:0] quote;
        logic [BYTE_W-1:0] line_end1;
        logic [BYTE_W-1:0] line_end2;
    } csq_cfg_t;

endpackage

### rtl/core/csv_strict_quote_tokenizer_top.sv
// ----------------------------------------------------------------------------
// Strict-quote CSV tokenizer
// Byte-serial CSV field tokenizer with strict quoting rules.
// ----------------------------------------------------------------------------
// Takes one byte of CSV text per request and returns at most one token: a
// data byte, a field end, a record end or an error. The block sustains one
// byte per clock while neither in_stall nor out_stall holds it; a byte whose
// token exists passes through the front register and a queue entry before
// the result register takes it and shows it on the result channel, and a
// quote that only changes state gives no token. The rate is set by the state
// update in the back end. Errors are sticky until reset. Configuration
// registers may be written only while no byte is in flight.
module csv_strict_quote_tokenizer_top #(
    parameter int unsigned QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [csq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [csq_pkg::BYTE_W-1:0]      cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [csq_pkg::BYTE_W-1:0]      in_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [csq_pkg::KIND_W-1:0]      token_kind,
    output logic [csq_pkg::BYTE_W-1:0]      field_byte
);
    import csq_pkg::*;

    csq_cfg_t   cfg_reg;
    csq_cfg_t   cfg_next;
    logic       push;
    csq_class_t push_item;
    logic       queue_full;
    logic       pop;
    logic       not_empty;
    csq_class_t pop_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DELIMITER: cfg_next.delimiter = cfg_wdata;
                CFG_QUOTE:     cfg_next.quote     = cfg_wdata;
                CFG_LINE_END1: cfg_next.line_end1 = cfg_wdata;
                CFG_LINE_END2: cfg_next.line_end2 = cfg_wdata;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delimiter <= RST_DELIMITER;
            cfg_reg.quote     <= RST_QUOTE;
            cfg_reg.line_end1 <= RST_LINE_END1;
            cfg_reg.line_end2 <= RST_LINE_END2;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    csq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    csq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_item  (pop_item)
    );

    csq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .not_empty  (not_empty),
        .pop_item   (pop_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .token_kind (token_kind),
        .field_byte (field_byte)
    );

endmodule

### rtl/core/csq_front.sv
// ----------------------------------------------------------------------------
// CSV tokenizer front end
// Accepts input bytes, matches them against the configured special bytes and
// holds the classified request until the queue takes it.
// ----------------------------------------------------------------------------
module csq_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  csq_pkg::csq_cfg_t            cfg,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [csq_pkg::BYTE_W-1:0]   in_byte,
    output logic                         push,
    output csq_pkg::csq_class_t          push_item,
    input  logic                         queue_full
);
    import csq_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    csq_class_t item_reg;
    csq_class_t item_next;
    logic       accept;
    logic       handed_off;

    assign handed_off = valid_reg && !queue_full;
    assign in_stall   = valid_reg && queue_full;
    assign accept     = in_valid && !in_stall;
    assign push       = handed_off;
    assign push_item  = item_reg;

    always_comb
    begin
        item_next          = item_reg;
        valid_next         = valid_reg;
        if (handed_off)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next          = 1'b1;
            item_next.data      = in_byte;
            item_next.is_nl     = (in_byte == cfg.line_end1) || (in_byte == cfg.line_end2);
            item_next.delim_hit = (in_byte == cfg.delimiter);
            item_next.quote_hit = (in_byte == cfg.quote);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

### rtl/core/csq_queue.sv
// ----------------------------------------------------------------------------
// CSV tokenizer request queue
// Small FIFO of classified bytes between the front end and the back end.
// ----------------------------------------------------------------------------
module csq_queue #(
    parameter int unsigned DEPTH = csq_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  csq_pkg::csq_class_t   push_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output csq_pkg::csq_class_t   pop_item
);
    import csq_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    csq_class_t    mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(DEPTH))
        else $error("queue count exceeds depth");
    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("push into a full queue");
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && !not_empty))
        else $error("pop from an empty queue");

endmodule

### rtl/core/csq_back.sv
// ----------------------------------------------------------------------------
// CSV tokenizer back end
// Runs the quoting state machine over classified bytes and drives the result
// register.
// ----------------------------------------------------------------------------
module csq_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         not_empty,
    input  csq_pkg::csq_class_t          pop_item,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [csq_pkg::KIND_W-1:0]   token_kind,
    output logic [csq_pkg::BYTE_W-1:0]   field_byte
);
    import csq_pkg::*;

    typedef enum logic [2:0] {
        ST_FIELD_START = 3'd0,
        ST_UNQUOTED    = 3'd1,
        ST_QUOTED      = 3'd2,
        ST_QUOTE_SEEN  = 3'd3,
        ST_ERROR       = 3'd4
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [KIND_W-1:0]   kind_reg;
    logic [KIND_W-1:0]   kind_next;
    logic [BYTE_W-1:0]   byte_reg;
    logic [BYTE_W-1:0]   byte_next;
    logic                emit;
    logic [KIND_W-1:0]   emit_kind;

    // The result register frees up when it is empty or being taken this cycle.
    assign pop        = not_empty && (!out_valid_reg || !out_stall);
    assign out_valid  = out_valid_reg;
    assign token_kind = kind_reg;
    assign field_byte = byte_reg;

    always_comb
    begin
        state_next = state_reg;
        emit       = 1'b1;
        emit_kind  = KIND_DATA;
        unique case (state_reg)
            ST_FIELD_START, ST_UNQUOTED:
            begin
                if (pop_item.is_nl)
                begin
                    state_next = ST_FIELD_START;
                    emit_kind  = KIND_RECORD_END;
                end
                else if (pop_item.delim_hit)
                begin
                    state_next = ST_FIELD_START;
                    emit_kind  = KIND_FIELD_END;
                end
                else if (pop_item.quote_hit)
                begin
                    if (state_reg == ST_FIELD_START)
                    begin
                        state_next = ST_QUOTED;
                        emit       = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_ERROR;
                        emit_kind  = KIND_ERROR;
                    end
                end
                else
                begin
                    state_next = ST_UNQUOTED;
                end
            end
            ST_QUOTED:
            begin
                if (pop_item.quote_hit)
                begin
                    state_next = ST_QUOTE_SEEN;
                    emit       = 1'b0;
                end
            end
            ST_QUOTE_SEEN:
            begin
                // A second quote is an escaped literal quote.
                if (pop_item.quote_hit)
                begin
                    state_next = ST_QUOTED;
                end
                else if (pop_item.is_nl)
                begin
                    state_next = ST_FIELD_START;
                    emit_kind  = KIND_RECORD_END;
                end
                else if (pop_item.delim_hit)
                begin
                    state_next = ST_FIELD_START;
                    emit_kind  = KIND_FIELD_END;
                end
                else
                begin
                    state_next = ST_ERROR;
                    emit_kind  = KIND_ERROR;
                end
            end
            default:
            begin
                state_next = ST_ERROR;
                emit_kind  = KIND_ERROR;
            end
        endcase

        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        if (!pop)
        begin
            state_next = state_reg;
        end
        else if (emit)
        begin
            out_valid_next = 1'b1;
            kind_next      = emit_kind;
            byte_next      = (emit_kind == KIND_DATA) ? pop_item.data : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FIELD_START;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_DATA;
            byte_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            byte_reg      <= byte_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ERROR |=> state_reg == ST_ERROR)
        else $error("error state was left");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ERROR && pop) |=> (out_valid_reg && kind_reg == KIND_ERROR))
        else $error("byte in error state did not give an error token");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_DATA) |-> byte_reg == '0)
        else $error("non-data token carries a nonzero byte");

endmodule

### verif/csq_checker.sv
// ----------------------------------------------------------------------------
// CSV tokenizer checker
// Watches the configuration port and the input and result channels of the tokenizer.
// It predicts the token, if any, of every accepted byte and compares each token that
// leaves the block against the oldest prediction.
// ----------------------------------------------------------------------------
module csq_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [csq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [csq_pkg::BYTE_W-1:0]      cfg_wdata,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [csq_pkg::BYTE_W-1:0]      in_byte,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [csq_pkg::KIND_W-1:0]      token_kind,
    input  logic [csq_pkg::BYTE_W-1:0]      field_byte,
    output int unsigned                     pending,
    output int unsigned                     failures
);

    import csq_pkg::*;

    typedef enum logic [2:0] {
        PS_FIELD_START,
        PS_UNQUOTED,
        PS_QUOTED,
        PS_QUOTE_SEEN,
        PS_ERROR
    } parse_state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
    } token_t;

    csq_cfg_t     chars;
    parse_state_t pstate;
    token_t       token_q[$];

    // Advances the parse state by one byte. Returns 0 when the byte only
    // changes state, as an opening or a closing quote does.
    function automatic bit next_token(input logic [BYTE_W-1:0] b, output token_t tok);
        logic nl;
        logic delim;
        logic quote;
        nl    = (b == chars.line_end1) || (b == chars.line_end2);
        delim = (b == chars.delimiter);
        quote = (b == chars.quote);
        tok.kind = KIND_DATA;
        tok.data = b;
        case (pstate)
            PS_FIELD_START, PS_UNQUOTED:
            begin
                if (nl)
                begin
                    pstate   = PS_FIELD_START;
                    tok.kind = KIND_RECORD_END;
                end
                else if (delim)
                begin
                    pstate   = PS_FIELD_START;
                    tok.kind = KIND_FIELD_END;
                end
                else if (quote)
                begin
                    if (pstate == PS_FIELD_START)
                    begin
                        pstate = PS_QUOTED;
                        return 1'b0;
                    end
                    pstate   = PS_ERROR;
                    tok.kind = KIND_ERROR;
                end
                else
                begin
                    pstate = PS_UNQUOTED;
                end
            end
            PS_QUOTED:
            begin
                if (quote)
                begin
                    pstate = PS_QUOTE_SEEN;
                    return 1'b0;
                end
            end
            PS_QUOTE_SEEN:
            begin
                // A second quote is a literal one and takes precedence over
                // any line-end or delimiter that shares its value.
                if (quote)
                begin
                    pstate = PS_QUOTED;
                end
                else if (nl)
                begin
                    pstate   = PS_FIELD_START;
                    tok.kind = KIND_RECORD_END;
                end
                else if (delim)
                begin
                    pstate   = PS_FIELD_START;
                    tok.kind = KIND_FIELD_END;
                end
                else
                begin
                    pstate   = PS_ERROR;
                    tok.kind = KIND_ERROR;
                end
            end
            default:
            begin
                pstate   = PS_ERROR;
                tok.kind = KIND_ERROR;
            end
        endcase
        if (tok.kind != KIND_DATA)
        begin
            tok.data = '0;
        end
        return 1'b1;
    endfunction

    task automatic report(input string what);
        $display("[%0t] token mismatch: %s", $time, what);
        failures++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        token_t tok;
        token_t want;
        if (!rst_n)
        begin
            chars    = '{RST_DELIMITER, RST_QUOTE, RST_LINE_END1, RST_LINE_END2};
            pstate   = PS_FIELD_START;
            token_q.delete();
            pending  = 0;
            failures = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (token_q.size() == 0)
                begin
                    report($sformatf("unexpected token kind %0d byte %0h",
                                     token_kind, field_byte));
                end
                else
                begin
                    want = token_q.pop_front();
                    if (token_kind !== want.kind)
                    begin
                        report($sformatf("kind %0d, expected %0d", token_kind, want.kind));
                    end
                    if (field_byte !== want.data)
                    begin
                        report($sformatf("byte %0h, expected %0h", field_byte, want.data));
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (next_token(in_byte, tok))
                begin
                    token_q.push_back(tok);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DELIMITER: chars.delimiter = cfg_wdata;
                    CFG_QUOTE:     chars.quote     = cfg_wdata;
                    CFG_LINE_END1: chars.line_end1 = cfg_wdata;
                    CFG_LINE_END2: chars.line_end2 = cfg_wdata;
                    default: ;
                endcase
            end
            pending = token_q.size();
        end
    end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// CSV tokenizer testbench
// Feeds the tokenizer a directed opening stream, then well-formed random
// records under several delimiter, quote and line-end settings, and at last
// a broken stream that drives it into its sticky error state. Both channels
// idle at random; the checker beside the block judges every token.
// ----------------------------------------------------------------------------
module tb_top;

    import csq_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 100000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PHASE_BYTES  = 52;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_wdata;
    logic                 in_valid;
    logic                 in_stall;
    logic [BYTE_W-1:0]    in_byte;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [KIND_W-1:0]    token_kind;
    logic [BYTE_W-1:0]    field_byte;

    int unsigned pending;
    int unsigned failures;
    int unsigned cycles = 0;
    int unsigned sent   = 0;
    logic        calm;
    csq_cfg_t    chars = '{RST_DELIMITER, RST_QUOTE, RST_LINE_END1, RST_LINE_END2};

    // Opening stream under the reset settings: extreme data bytes, empty
    // fields, delimiters and line ends inside quotes, doubled quotes, an
    // empty quoted field and back-to-back line ends.
    logic [BYTE_W-1:0] opening[$] = {
        8'h80, 8'h00, 8'hFF, ",", ",",
        "\"", "a", ",", "\n", "\"", "\"", "\"", ",",
        "\"", "\"", 8'd13, 8'd13, 8'd10,
        "x", 8'd10,
        "\"", "\"", "\"", "\"", 8'd10
    };

    // Neither side idles while this window of requests goes through.
    assign calm = (sent >= 150) && (sent < 300);

    csv_strict_quote_tokenizer_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .token_kind (token_kind),
        .field_byte (field_byte)
    );

    csq_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .token_kind (token_kind),
        .field_byte (field_byte),
        .pending    (pending),
        .failures   (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < 9);
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (!calm && ($urandom_range(0, 99) < 9))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sent++;
    endtask

    // A byte that matches none of the four special characters.
    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        do
        begin
            b = 8'($urandom_range(0, 255));
        end
        while (b == chars.delimiter || b == chars.quote ||
               b == chars.line_end1 || b == chars.line_end2);
        return b;
    endfunction

    task automatic send_field();
        int unsigned shape;
        int unsigned len;
        int unsigned pick;
        shape = $urandom_range(0, 9);
        len   = $urandom_range(0, 6);
        if (shape < 4)
        begin
            repeat (len) send_byte(plain_byte());
        end
        else if (shape < 9)
        begin
            send_byte(chars.quote);
            repeat (len)
            begin
                pick = $urandom_range(0, 9);
                case (pick)
                    6: send_byte(chars.delimiter);
                    7: send_byte(chars.line_end1);
                    8: send_byte(chars.line_end2);
                    9:
                    begin
                        send_byte(chars.quote);
                        send_byte(chars.quote);
                    end
                    default: send_byte(plain_byte());
                endcase
            end
            send_byte(chars.quote);
        end
    endtask

    task automatic send_record();
        int unsigned nfields;
        nfields = $urandom_range(1, 4);
        for (int unsigned f = 0; f < nfields; f++)
        begin
            if (f != 0)
            begin
                send_byte(chars.delimiter);
            end
            send_field();
        end
        send_byte($urandom_range(0, 1) ? chars.line_end1 : chars.line_end2);
        // Now and then a second line end, as in a CR LF pair or an empty record.
        if ($urandom_range(0, 7) == 0)
        begin
            send_byte(chars.line_end2);
        end
    endtask

    task automatic run_phase(input int unsigned nbytes);
        int unsigned start;
        start = sent;
        while (sent - start < nbytes)
        begin
            send_record();
        end
    endtask

    // A closing quote gives no token, so drain keeps waiting after no token is
    // pending before the block counts as idle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_chars(input logic [BYTE_W-1:0] delim, input logic [BYTE_W-1:0] quote,
                             input logic [BYTE_W-1:0] nl1, input logic [BYTE_W-1:0] nl2);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DELIMITER;
        cfg_wdata <= delim;
        @(posedge clk);
        cfg_index <= CFG_QUOTE;
        cfg_wdata <= quote;
        @(posedge clk);
        cfg_index <= CFG_LINE_END1;
        cfg_wdata <= nl1;
        @(posedge clk);
        cfg_index <= CFG_LINE_END2;
        cfg_wdata <= nl2;
        @(posedge clk);
        cfg_we <= 1'b0;
        chars  = '{delim, quote, nl1, nl2};
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_DELIMITER;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        in_byte   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
        begin
            send_byte(opening[i]);
        end

        set_chars(8'd0, 8'd255, 8'd1, 8'd128);
        run_phase(PHASE_BYTES);
        // The delimiter shares its value with a line end, which wins.
        set_chars(8'd255, 8'd0, 8'd255, 8'd127);
        run_phase(PHASE_BYTES);
        // The quote equals the delimiter, so it can never open a field.
        set_chars(8'd9, 8'd9, 8'd0, 8'd10);
        run_phase(PHASE_BYTES);
        // The quote equals a line end and acts as one.
        set_chars(8'd59, 8'd39, 8'd10, 8'd39);
        run_phase(PHASE_BYTES);
        repeat (4)
        begin
            set_chars(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            run_phase(PHASE_BYTES);
        end

        // The error state holds until reset, so it is entered only at the end.
        set_chars(RST_DELIMITER, RST_QUOTE, RST_LINE_END1, RST_LINE_END2);
        run_phase(20);
        if ($urandom_range(0, 1))
        begin
            // Stray quote inside an unquoted field.
            send_byte(plain_byte());
            send_byte(chars.quote);
        end
        else
        begin
            // Data straight after a closing quote.
            send_byte(chars.quote);
            send_byte(plain_byte());
            send_byte(chars.quote);
            send_byte(plain_byte());
        end
        repeat (40) send_byte(8'($urandom_range(0, 255)));
        drain();

        if (failures == 0 && pending == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
